[src/rtcab_pkg.sv]
// Package for the BCD real-time clock register block: register addresses, opcodes, masks
// and the BCD calendar helper functions. No dependencies.
`default_nettype none
package rtcab_pkg;
    localparam int REG_COUNT_DEF = 19;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_TEMP  = 2'd3;

    localparam logic [4:0] ADDR_SEC    = 5'h00;
    localparam logic [4:0] ADDR_MIN    = 5'h01;
    localparam logic [4:0] ADDR_HOUR   = 5'h02;
    localparam logic [4:0] ADDR_DAY    = 5'h03;
    localparam logic [4:0] ADDR_DATE   = 5'h04;
    localparam logic [4:0] ADDR_MONTH  = 5'h05;
    localparam logic [4:0] ADDR_YEAR   = 5'h06;
    localparam logic [4:0] ADDR_A1SEC  = 5'h07;
    localparam logic [4:0] ADDR_A1MIN  = 5'h08;
    localparam logic [4:0] ADDR_A1HOUR = 5'h09;
    localparam logic [4:0] ADDR_A1DAY  = 5'h0A;
    localparam logic [4:0] ADDR_A2MIN  = 5'h0B;
    localparam logic [4:0] ADDR_A2HOUR = 5'h0C;
    localparam logic [4:0] ADDR_A2DAY  = 5'h0D;
    localparam logic [4:0] ADDR_CTRL   = 5'h0E;
    localparam logic [4:0] ADDR_STAT   = 5'h0F;
    localparam logic [4:0] ADDR_TEMPH  = 5'h11;
    localparam logic [4:0] ADDR_TEMPL  = 5'h12;

    localparam logic [7:0] CTRL_RESET = 8'h1C;
    localparam logic [7:0] STAT_RESET = 8'h88;

    typedef logic [7:0] t_byte;

    // Bits that exist in each register; zero means read-only.
    function automatic t_byte write_mask(input logic [4:0] addr);
        t_byte m;
        begin
            case (addr)
                ADDR_SEC, ADDR_MIN, ADDR_HOUR: m = 8'h7F;
                ADDR_DAY:   m = 8'h07;
                ADDR_DATE:  m = 8'h3F;
                ADDR_MONTH: m = 8'h9F;
                5'h10:      m = 8'hFF;
                ADDR_STAT, ADDR_TEMPH, ADDR_TEMPL: m = 8'h00;
                default:    m = (addr < ADDR_STAT) ? 8'hFF : 8'h00;
            endcase
            return m;
        end
    endfunction

    // Binary value (0..99, wider for bad BCD) of a BCD byte with a tens mask.
    function automatic logic [7:0] bcd_val(input t_byte v, input logic [3:0] tens);
        logic [7:0] t;
        begin
            t = {4'd0, v[7:4] & tens};
            return {4'd0, v[3:0]} + (t << 3) + (t << 1);
        end
    endfunction

    // BCD encoding of a byte value. The tens digit keeps only its low four bits, so
    // values of 160 and above wrap. The quotient by ten uses a reciprocal multiply.
    function automatic t_byte bcd_make(input logic [7:0] n);
        logic [15:0] p;
        logic [7:0]  tn;
        logic [7:0]  rem;
        begin
            p   = {8'd0, n} * 16'd205;
            tn  = {3'd0, p[15:11]};
            rem = n - ((tn << 3) + (tn << 1));
            return {tn[3:0], rem[3:0]};
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] month, input logic leap);
        logic [4:0] d;
        begin
            case (month)
                8'd2:                    d = leap ? 5'd29 : 5'd28;
                8'd4, 8'd6, 8'd9, 8'd11: d = 5'd30;
                default:                 d = 5'd31;
            endcase
            return d;
        end
    endfunction

    function automatic logic field_match(input t_byte alarm, input t_byte now);
        return alarm[7] || (alarm[6:0] == now[6:0]);
    endfunction
endpackage
`default_nettype wire

[src/bcd_rtc_alarm_register_block_top.sv]
// Top level of the BCD real-time clock register block: register file, handshake and result
// register. Depends on rtcab_pkg and rtcab_tick.
`default_nettype none
// The block takes one transfer per cycle while it does not stall its input and returns one result
// transfer for each, registered at acceptance; the register file update and
// the calendar advance happen in the same cycle the item is accepted. A result register
// with a skid stage parts the two channels, so the input stalls only when both hold a
// result. Every result carries the read byte (zero for anything but a read), the
// interrupt line and both alarm flags as they stand after the item is applied.
module bcd_rtc_alarm_register_block_top import rtcab_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [1:0] i_opcode,
    input  wire  [4:0] i_reg_addr,
    input  wire  [7:0] i_write_data,
    input  wire signed [9:0] i_temp_sample,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_read_data,
    output logic       o_int_out_n,
    output logic       o_alarm1_flag,
    output logic       o_alarm2_flag
);
    t_byte r_regs [REG_COUNT];
    t_byte n_regs [REG_COUNT];

    logic       r_valid, r_skid_valid;
    logic [10:0] r_res, r_skid, n_res;
    logic       accept;

    t_byte tk_sec, tk_min, tk_hour, tk_day, tk_date, tk_month, tk_year;
    logic  a1_hit, a2_hit;

    rtcab_tick u_tick (
        .i_sec(r_regs[ADDR_SEC]), .i_min(r_regs[ADDR_MIN]), .i_hour(r_regs[ADDR_HOUR]),
        .i_day(r_regs[ADDR_DAY]), .i_date(r_regs[ADDR_DATE]),
        .i_month(r_regs[ADDR_MONTH]), .i_year(r_regs[ADDR_YEAR]),
        .i_a1s(r_regs[ADDR_A1SEC]), .i_a1m(r_regs[ADDR_A1MIN]),
        .i_a1h(r_regs[ADDR_A1HOUR]), .i_a1d(r_regs[ADDR_A1DAY]),
        .i_a2m(r_regs[ADDR_A2MIN]), .i_a2h(r_regs[ADDR_A2HOUR]),
        .i_a2d(r_regs[ADDR_A2DAY]),
        .o_sec(tk_sec), .o_min(tk_min), .o_hour(tk_hour), .o_day(tk_day),
        .o_date(tk_date), .o_month(tk_month), .o_year(tk_year),
        .o_a1_hit(a1_hit), .o_a2_hit(a2_hit)
    );

    // The input stalls only while the skid stage is occupied.
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    always_comb begin
        t_byte rd;
        t_byte ctl;
        t_byte st;
        rd = 8'h00;
        for (int k = 0; k < REG_COUNT; k++) begin
            n_regs[k] = r_regs[k];
        end
        case (i_opcode)
            OP_READ: begin
                if (i_reg_addr < 5'(REG_COUNT)) begin
                    rd = r_regs[i_reg_addr];
                end
            end
            OP_WRITE: begin
                if (i_reg_addr == ADDR_STAT) begin
                    // Alarm and oscillator flags can only be cleared by software.
                    n_regs[ADDR_STAT] = (r_regs[ADDR_STAT] & i_write_data & 8'h83) |
                                        (i_write_data & 8'h08);
                end else if (i_reg_addr < 5'(REG_COUNT) &&
                             write_mask(i_reg_addr) != 8'h00) begin
                    n_regs[i_reg_addr] = i_write_data & write_mask(i_reg_addr);
                end
            end
            OP_TICK: begin
                n_regs[ADDR_SEC]   = tk_sec;
                n_regs[ADDR_MIN]   = tk_min;
                n_regs[ADDR_HOUR]  = tk_hour;
                n_regs[ADDR_DAY]   = tk_day;
                n_regs[ADDR_DATE]  = tk_date;
                n_regs[ADDR_MONTH] = tk_month;
                n_regs[ADDR_YEAR]  = tk_year;
                n_regs[ADDR_STAT]  = r_regs[ADDR_STAT] | {6'd0, a2_hit, a1_hit};
            end
            default: begin
                n_regs[ADDR_TEMPH] = i_temp_sample[9:2];
                n_regs[ADDR_TEMPL] = {i_temp_sample[1:0], 6'd0};
            end
        endcase
        ctl = n_regs[ADDR_CTRL];
        st  = n_regs[ADDR_STAT];
        n_res = {rd, !(ctl[2] && ((ctl[1:0] & st[1:0]) != 2'b00)), st[0], st[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= 8'h00;
            end
            r_regs[ADDR_DAY]   <= 8'h01;
            r_regs[ADDR_DATE]  <= 8'h01;
            r_regs[ADDR_MONTH] <= 8'h01;
            r_regs[ADDR_CTRL]  <= CTRL_RESET;
            r_regs[ADDR_STAT]  <= STAT_RESET;
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                for (int k = 0; k < REG_COUNT; k++) begin
                    r_regs[k] <= n_regs[k];
                end
            end
            if (!r_valid || !i_stall) begin
                // Output register free or draining: refill from the skid stage first.
                if (r_skid_valid) begin
                    r_res        <= r_skid;
                    r_valid      <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= accept;
                    if (accept) begin
                        r_res <= n_res;
                    end
                end
            end else if (accept) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_read_data   = r_res[10:3];
    assign o_int_out_n   = r_res[2];
    assign o_alarm1_flag = r_res[1];
    assign o_alarm2_flag = r_res[0];
endmodule
`default_nettype wire

[src/rtcab_tick.sv]
// Calendar advance for one second tick and alarm compares on the advanced time.
// Depends on rtcab_pkg.
`default_nettype none
module rtcab_tick import rtcab_pkg::*; (
    input  wire t_byte i_sec,
    input  wire t_byte i_min,
    input  wire t_byte i_hour,
    input  wire t_byte i_day,
    input  wire t_byte i_date,
    input  wire t_byte i_month,
    input  wire t_byte i_year,
    input  wire t_byte i_a1s,
    input  wire t_byte i_a1m,
    input  wire t_byte i_a1h,
    input  wire t_byte i_a1d,
    input  wire t_byte i_a2m,
    input  wire t_byte i_a2h,
    input  wire t_byte i_a2d,
    output t_byte o_sec,
    output t_byte o_min,
    output t_byte o_hour,
    output t_byte o_day,
    output t_byte o_date,
    output t_byte o_month,
    output t_byte o_year,
    output logic  o_a1_hit,
    output logic  o_a2_hit
);
    logic [7:0] s_v, m_v, h12, h_v, dt_v, mo_v, yr_v;
    logic       c_s, c_m, c_h;
    logic [4:0] dim;
    logic [7:0] h_n;

    always_comb begin
        s_v = bcd_val(i_sec, 4'h7) + 8'd1;
        c_s = s_v >= 8'd60;
        o_sec = c_s ? 8'h00 : bcd_make(s_v);

        m_v = bcd_val(i_min, 4'h7) + 8'd1;
        c_m = c_s && (m_v >= 8'd60);
        o_min = !c_s ? i_min : ((m_v >= 8'd60) ? 8'h00 : bcd_make(m_v));

        h12 = bcd_val(i_hour, 4'h1);
        if (i_hour[6]) begin
            h_v = ((h12 == 8'd12) ? 8'd0 : h12) + (i_hour[5] ? 8'd12 : 8'd0) + 8'd1;
        end else begin
            h_v = bcd_val(i_hour, 4'h3) + 8'd1;
        end
        c_h = c_m && (h_v >= 8'd24);
        h_n = (h_v >= 8'd24) ? 8'd0 : h_v;
        if (!c_m) begin
            o_hour = i_hour;
        end else if (i_hour[6]) begin
            o_hour = {1'b0, 1'b1, h_n >= 8'd12, 5'd0} |
                bcd_make((h_n == 8'd0 || h_n == 8'd12) ? 8'd12 :
                         (h_n > 8'd12 ? h_n - 8'd12 : h_n));
        end else begin
            o_hour = bcd_make(h_n);
        end

        dt_v = bcd_val(i_date, 4'h3) + 8'd1;
        mo_v = bcd_val(i_month, 4'h1);
        yr_v = bcd_val(i_year, 4'hF);
        dim  = month_len(mo_v, yr_v[1:0] == 2'd0);
        o_day = i_day;
        o_date = i_date;
        o_month = i_month;
        o_year = i_year;
        if (c_h) begin
            // A calendar step re-encodes month and year even without a carry.
            o_day = (i_day[2:0] == 3'd7 || i_day[2:0] == 3'd0) ? 8'd1
                                                                : {5'd0, i_day[2:0] + 3'd1};
            o_date  = bcd_make(dt_v);
            o_month = {i_month[7], 7'd0} | bcd_make(mo_v);
            o_year  = bcd_make(yr_v);
            if (dt_v > {3'd0, dim}) begin
                o_date = 8'h01;
                if (mo_v + 8'd1 > 8'd12) begin
                    o_month = {i_month[7], 7'h01};
                    if (yr_v + 8'd1 >= 8'd100) begin
                        o_year = 8'h00;
                        o_month[7] = ~i_month[7];
                    end else begin
                        o_year = bcd_make(yr_v + 8'd1);
                    end
                end else begin
                    o_month = {i_month[7], 7'd0} | bcd_make(mo_v + 8'd1);
                end
            end
        end

        o_a1_hit = field_match(i_a1s, o_sec) && field_match(i_a1m, o_min) &&
                   field_match(i_a1h, o_hour) &&
                   (i_a1d[7] || (i_a1d[6] ? (i_a1d[3:0] == o_day[3:0])
                                          : (i_a1d[5:0] == o_date[5:0])));
        o_a2_hit = (o_sec == 8'h00) && field_match(i_a2m, o_min) &&
                   field_match(i_a2h, o_hour) &&
                   (i_a2d[7] || (i_a2d[6] ? (i_a2d[3:0] == o_day[3:0])
                                          : (i_a2d[5:0] == o_date[5:0])));
    end
endmodule
`default_nettype wire

[src/rtcab_checker.sv]
// Port-level checker for the BCD real-time clock register block, bound to its top level.
// Depends on rtcab_pkg.
`default_nettype none
module rtcab_checker import rtcab_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_read_data,
    input wire       o_int_out_n,
    input wire       o_alarm1_flag,
    input wire       o_alarm2_flag
);
    // The read byte of a stalled result does not change.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data))
        else $error("result changed under stall");
    // An accepted item with a free output shows up the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> o_valid)
        else $error("result lost");
    // The input only stalls while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without pending result");
    // Interrupt low requires an alarm flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_int_out_n |-> o_alarm1_flag || o_alarm2_flag)
        else $error("interrupt without flag");
endmodule

bind bcd_rtc_alarm_register_block_top rtcab_checker u_checker (.*);
`default_nettype wire
